/* rtl/mte_pkg.sv */
// Package for the multitap echo with damping: sizes, register codes and
// the control structs shared by the datapath modules. No dependencies.
`timescale 1ns / 1ps

package mte_pkg;

  // History ring, a power of two deep
  localparam int HISTORY_DEPTH = 65536;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int FILL_W        = HIST_AW + 1;

  // Taps: TAPS is the build limit, REG_TAPS the taps that have registers
  localparam int TAPS       = 3;
  localparam int REG_TAPS   = 3;
  localparam int N_TAPS_MAX = (TAPS < REG_TAPS) ? TAPS : REG_TAPS;
  localparam int TAP_W      = $clog2(REG_TAPS + 1);

  localparam int SMP_W     = 16;
  localparam int COEF_W    = 16;
  localparam int CNT_REG_W = 2;
  localparam int FILT_W    = 33;   // Q17.16 lowpass state
  localparam int CFG_IDX_W = 3;

  // Shared multiplier operands
  localparam int MUL_A_W = FILT_W + 1;
  localparam int MUL_B_W = COEF_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 3'd0,
    REG_DELAY_A   = 3'd1,
    REG_DELAY_B   = 3'd2,
    REG_DELAY_C   = 3'd3,
    REG_GAIN_A    = 3'd4,
    REG_GAIN_B    = 3'd5,
    REG_GAIN_C    = 3'd6,
    REG_DAMPING   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_REG_W-1:0]             tap_count;
    logic [REG_TAPS-1:0][COEF_W-1:0]  delay;
    logic [REG_TAPS-1:0][COEF_W-1:0]  gain;
    logic [COEF_W-1:0]                damping;
  } cfg_t;

  typedef struct packed {
    logic              rd_en;
    logic [COEF_W-1:0] rd_delay;
    logic              wr_en;
  } hist_ctl_t;

endpackage

/* rtl/mte_dry_if.sv */
// Input channel: one dry sample word with valid/ready.
// Depends on mte_pkg.
`timescale 1ns / 1ps

interface mte_dry_if import mte_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] dry_sample;

  modport source (output valid, output dry_sample, input ready);
  modport sink   (input valid, input dry_sample, output ready);
endinterface

/* rtl/mte_wet_if.sv */
// Output channel: one wet sample word with valid/ready.
// Depends on mte_pkg.
`timescale 1ns / 1ps

interface mte_wet_if import mte_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] wet_sample;

  modport source (output valid, output wet_sample, input ready);
  modport sink   (input valid, input wet_sample, output ready);
endinterface

/* rtl/mte_cfg_regs.sv */
// Configuration register file: tap count, delays, gains and damping.
// Depends on mte_pkg.
`timescale 1ns / 1ps

module mte_cfg_regs import mte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_count <= '0;
      for (int i = 0; i < REG_TAPS; i++) begin
        cfg_q.delay[i] <= COEF_W'(1);
        cfg_q.gain[i]  <= '0;
      end
      cfg_q.damping <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TAP_COUNT: cfg_q.tap_count <= cfg_data_i[CNT_REG_W-1:0];
        REG_DELAY_A:   cfg_q.delay[0]  <= cfg_data_i;
        REG_DELAY_B:   cfg_q.delay[1]  <= cfg_data_i;
        REG_DELAY_C:   cfg_q.delay[2]  <= cfg_data_i;
        REG_GAIN_A:    cfg_q.gain[0]   <= cfg_data_i;
        REG_GAIN_B:    cfg_q.gain[1]   <= cfg_data_i;
        REG_GAIN_C:    cfg_q.gain[2]   <= cfg_data_i;
        REG_DAMPING:   cfg_q.damping   <= cfg_data_i;
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/mte_mul.sv */
// Shared signed multiplier with registered product, used by taps and filter.
// Depends on mte_pkg.
`timescale 1ns / 1ps

module mte_mul import mte_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

/* rtl/mte_history.sv */
// History ring of past wet words: memory, write pointer and fill count.
// Slots not yet written since reset read as zero. Depends on mte_pkg.
`timescale 1ns / 1ps

module mte_history import mte_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hist_ctl_t               ctl_i,
  input  logic signed [SMP_W-1:0] wr_data_i,
  output logic signed [SMP_W-1:0] rd_data_o
);

  localparam int CMP_W = (FILL_W > COEF_W) ? FILL_W : COEF_W;

  logic signed [SMP_W-1:0] mem [HISTORY_DEPTH];
  logic signed [SMP_W-1:0] rd_q;
  logic                    rd_ok_q;
  logic [HIST_AW-1:0]      wr_idx_q;
  logic [FILL_W-1:0]       fill_q;
  logic [CMP_W-1:0]        dly_raw;
  logic [CMP_W-1:0]        dly_eff;
  logic [HIST_AW-1:0]      rd_addr;

  // delay 0 acts as 1, delay beyond the ring as the full ring
  always_comb begin
    dly_raw = CMP_W'(ctl_i.rd_delay);
    if (dly_raw == '0) begin
      dly_eff = CMP_W'(1);
    end else if (dly_raw > CMP_W'(HISTORY_DEPTH)) begin
      dly_eff = CMP_W'(HISTORY_DEPTH);
    end else begin
      dly_eff = dly_raw;
    end
    rd_addr = wr_idx_q - dly_eff[HIST_AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_idx_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      fill_q   <= '0;
      rd_ok_q  <= 1'b0;
    end else begin
      if (ctl_i.rd_en) begin
        rd_ok_q <= (dly_eff <= CMP_W'(fill_q));
      end
      if (ctl_i.wr_en) begin
        wr_idx_q <= wr_idx_q + HIST_AW'(1);
        if (fill_q != FILL_W'(HISTORY_DEPTH)) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
    end
  end

  assign rd_data_o = rd_ok_q ? rd_q : '0;

endmodule

/* rtl/multitap_echo_with_damping.sv */
// Multitap echo with one-pole lowpass damping: top level and sequencer.
// One word at a time through the shared multiplier: a new dry word is taken
// only once the last wet word has entered the output register, which waits
// while an earlier wet word is still held there. Zero to three taps are enabled;
// damping zero skips the filter multiply. Async reset clears control, filter and fill
// count; unwritten history reads zero. Uses mte_pkg, the channel ifs, submodules.
`timescale 1ns / 1ps

module multitap_echo_with_damping import mte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mte_dry_if.sink              dry_i,
  mte_wet_if.source            wet_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  localparam int ACC_W = SMP_W + 4;
  localparam int NUM_W = MUL_P_W + 1;

  // Sequencer: one tap is read, multiply, add; then filter multiply, add
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_TAP_RD  = 7'b0000010,
    ST_TAP_MUL = 7'b0000100,
    ST_TAP_ADD = 7'b0001000,
    ST_FLT_MUL = 7'b0010000,
    ST_FLT_ADD = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_e;

  state_e                   state_q, state_d;
  logic [TAP_W-1:0]         tap_q, tap_d;
  logic [TAP_W-1:0]         ntap_q, ntap_d;
  logic signed [SMP_W-1:0]  acc_q, acc_d;
  logic signed [FILT_W-1:0] flt_q, flt_d;
  logic signed [SMP_W-1:0]  wet_q, wet_d;
  logic                     wet_vld_q, wet_vld_d;

  cfg_t                      cfg;
  hist_ctl_t                 hctl;
  logic signed [SMP_W-1:0]   hist_rd;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic                      in_acc;
  logic                      out_free;
  logic [TAP_W-1:0]          ntap_cfg;
  logic signed [MUL_P_W-1:0] tap_rnd;
  logic signed [ACC_W-1:0]   tap_sum;
  logic signed [31:0]        acc_sh;
  logic signed [NUM_W-1:0]   num;
  logic signed [NUM_W-1:0]   num_sh;
  logic signed [FILT_W-1:0]  flt_new;
  logic signed [FILT_W:0]    flt_rnd;

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > ACC_W'(32767)) begin
      r = 16'sd32767;
    end else if (v < -ACC_W'(32767)) begin
      r = -16'sd32767;
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

  mte_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mte_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mte_history u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (hctl),
    .wr_data_i (acc_q),
    .rd_data_o (hist_rd)
  );

  assign in_acc   = dry_i.valid && dry_i.ready;
  assign out_free = !wet_vld_q || wet_o.ready;
  assign ntap_cfg = (TAP_W'(cfg.tap_count) > TAP_W'(N_TAPS_MAX)) ?
                    TAP_W'(N_TAPS_MAX) : TAP_W'(cfg.tap_count);

  // tap term rounds to nearest, ties up: (p + 2^14) >> 15
  assign tap_rnd = mul_p + MUL_P_W'(16384);
  assign tap_sum = ACC_W'(acc_q) + ACC_W'(tap_rnd >>> 15);

  // filter rewritten as acc*2^32 + d*(f - acc*2^16): one multiply
  assign acc_sh  = {acc_q, 16'h0000};
  assign num     = NUM_W'(signed'({acc_q, 32'h0})) + NUM_W'(mul_p) + NUM_W'(32768);
  assign num_sh  = num >>> 16;
  assign flt_new = num_sh[FILT_W-1:0];
  assign flt_rnd = (FILT_W+1)'(flt_new) + (FILT_W+1)'(32768);

  always_comb begin
    state_d   = state_q;
    tap_d     = tap_q;
    ntap_d    = ntap_q;
    acc_d     = acc_q;
    flt_d     = flt_q;
    wet_d     = wet_q;
    wet_vld_d = wet_vld_q;
    mul_en    = 1'b0;
    mul_a     = MUL_A_W'(hist_rd);
    mul_b     = MUL_B_W'(cfg.gain[tap_q]);
    hctl      = '{rd_en: 1'b0, rd_delay: cfg.delay[tap_q], wr_en: 1'b0};

    if (wet_vld_q && wet_o.ready) begin
      wet_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          acc_d   = sat16(ACC_W'(dry_i.dry_sample));
          tap_d   = '0;
          ntap_d  = ntap_cfg;
          state_d = (ntap_cfg != '0) ? ST_TAP_RD : ST_FLT_MUL;
        end
      end
      ST_TAP_RD: begin
        hctl.rd_en = 1'b1;
        state_d    = ST_TAP_MUL;
      end
      ST_TAP_MUL: begin
        mul_en  = 1'b1;
        state_d = ST_TAP_ADD;
      end
      ST_TAP_ADD: begin
        acc_d   = sat16(tap_sum);
        tap_d   = tap_q + TAP_W'(1);
        state_d = (tap_q + TAP_W'(1) < ntap_q) ? ST_TAP_RD : ST_FLT_MUL;
      end
      ST_FLT_MUL: begin
        if (cfg.damping != '0) begin
          mul_en  = 1'b1;
          mul_a   = MUL_A_W'(flt_q) - MUL_A_W'(acc_sh);
          mul_b   = MUL_B_W'(cfg.damping);
          state_d = ST_FLT_ADD;
        end else begin
          // bypass: the filter restarts from this word later
          flt_d   = FILT_W'(acc_sh);
          state_d = ST_DONE;
        end
      end
      ST_FLT_ADD: begin
        flt_d   = flt_new;
        acc_d   = sat16(ACC_W'(flt_rnd >>> 16));
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          hctl.wr_en = 1'b1;
          wet_d      = acc_q;
          wet_vld_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_q     <= '0;
      ntap_q    <= '0;
      flt_q     <= '0;
      wet_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_q     <= tap_d;
      ntap_q    <= ntap_d;
      flt_q     <= flt_d;
      wet_vld_q <= wet_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    wet_q <= wet_d;
  end

  assign dry_i.ready    = (state_q == ST_IDLE);
  assign wet_o.valid    = wet_vld_q;
  assign wet_o.wet_sample = wet_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ST_IDLE))
    else $error("sequencer idle right after taking a dry word");

  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAP_RD) |-> (tap_q < ntap_q))
    else $error("tap index beyond enabled taps");

  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (wet_vld_q && state_q == ST_IDLE))
    else $error("finished word not offered on the output");
`endif

endmodule
